### design/lr_pkg.sv
// Shared types and constants of the line rasterizer.
// Used by every module of the block; depends on nothing.
package lr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int COLOR_BITS  = 32;
    localparam int DEC_BITS    = COORD_BITS + 2;
    localparam int S_DATA_BITS = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef enum logic [2:0] {
        MODE_HORIZ,
        MODE_VERT,
        MODE_RISE_LOW,
        MODE_RISE_STEEP,
        MODE_FALL_LOW,
        MODE_FALL_STEEP
    } mode_t;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic signed [DEC_BITS-1:0] dec_t;

    typedef struct packed {
        logic                  start;
        mode_t                 mode;
        coord_t                cur_x;
        coord_t                cur_y;
        coord_t                stop;
        dec_t                  decision;
        dec_t                  step_straight;
        dec_t                  step_diagonal;
        logic [COLOR_BITS-1:0] color;
    } lr_cmd_t;

endpackage

### design/lr_front.sv
// Front end: unpacks input beats and classifies start items into a line setup.
// Depends on lr_pkg.
module lr_front
    import lr_pkg::*;
(
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_DATA_BITS-1:0] s_axis_tdata,  // start_x, start_y, end_x, end_y, line_color
    input  logic                   s_axis_tuser,  // kind
    output logic                   push_valid,
    input  logic                   push_ready,
    output lr_cmd_t                push_data
);

    coord_t                x0_in, y0_in, x1_in, y1_in;
    coord_t                x0, y0, x1, y1;
    coord_t                dx, ady, a, b;
    logic                  swap, shallow;
    logic [COLOR_BITS-1:0] color_in;

    assign x0_in    = s_axis_tdata[COORD_BITS-1:0];
    assign y0_in    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign x1_in    = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign y1_in    = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign color_in = s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];

    assign swap = x1_in < x0_in;
    assign x0   = swap ? x1_in : x0_in;
    assign y0   = swap ? y1_in : y0_in;
    assign x1   = swap ? x0_in : x1_in;
    assign y1   = swap ? y0_in : y1_in;

    assign dx      = x1 - x0;
    assign ady     = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
    assign shallow = ady <= dx;
    assign a       = shallow ? ady : dx;
    assign b       = shallow ? dx : ady;

    always_comb begin
        push_data               = '0;
        push_data.start         = (s_axis_tuser == KIND_START);
        push_data.color         = color_in;
        push_data.cur_x         = x0;
        push_data.cur_y         = y0;
        if (y1 == y0) begin
            push_data.mode = MODE_HORIZ;
            push_data.stop = x1;
        end else if (dx == '0) begin
            push_data.mode  = MODE_VERT;
            push_data.cur_y = (y0 < y1) ? y0 : y1;
            push_data.stop  = (y0 < y1) ? y1 : y0;
        end else begin
            if (y1 > y0) begin
                push_data.mode = shallow ? MODE_RISE_LOW : MODE_RISE_STEEP;
            end else begin
                push_data.mode = shallow ? MODE_FALL_LOW : MODE_FALL_STEEP;
            end
            push_data.stop          = shallow ? x1 : y1;
            push_data.step_straight = $signed({2'b00, a});
            push_data.step_diagonal = $signed({2'b00, a}) - $signed({2'b00, b});
            push_data.decision      = $signed({2'b00, a}) - $signed({3'b000, b[COORD_BITS-1:1]});
        end
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

endmodule

### design/lr_queue.sv
// Two-entry command queue between the front end and the pixel stepper.
// Depends on lr_pkg.
module lr_queue
    import lr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_valid,
    output logic    push_ready,
    input  lr_cmd_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output lr_cmd_t pop_data
);

    lr_cmd_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/lr_back.sv
// Pixel stepper: holds line state, emits a pixel per start and per step mid-line,
// updates the decision term, drives the registered output. Depends on lr_pkg.
module lr_back
    import lr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  lr_cmd_t                pop_data,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_DATA_BITS-1:0] m_axis_tdata,  // pixel_x, pixel_y, pixel_color
    output logic                   m_axis_tlast   // last_pixel
);

    logic                  busy_reg, busy_next;
    mode_t                 mode_reg, mode_next;
    coord_t                x_reg, x_next, y_reg, y_next, stop_reg, stop_next;
    dec_t                  dec_reg, dec_next, ss_reg, ss_next, sd_reg, sd_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;

    logic                  m_valid_reg, m_valid_next;
    coord_t                px_reg, px_next, py_reg, py_next;
    logic [COLOR_BITS-1:0] pc_reg, pc_next;
    logic                  plast_reg, plast_next;

    mode_t                 s_mode;
    coord_t                s_x, s_y, s_stop, a_x, a_y;
    dec_t                  s_dec, s_ss, s_sd, a_dec;
    logic [COLOR_BITS-1:0] s_color;
    logic                  do_pop, emit, last, major_x;

    assign pop_ready = !m_valid_reg || m_axis_tready;
    assign do_pop    = pop_valid && pop_ready;
    assign emit      = do_pop && (pop_data.start || busy_reg);

    always_comb begin
        if (pop_data.start) begin
            s_mode  = pop_data.mode;
            s_x     = pop_data.cur_x;
            s_y     = pop_data.cur_y;
            s_stop  = pop_data.stop;
            s_dec   = pop_data.decision;
            s_ss    = pop_data.step_straight;
            s_sd    = pop_data.step_diagonal;
            s_color = pop_data.color;
        end else begin
            s_mode  = mode_reg;
            s_x     = x_reg;
            s_y     = y_reg;
            s_stop  = stop_reg;
            s_dec   = dec_reg;
            s_ss    = ss_reg;
            s_sd    = sd_reg;
            s_color = color_reg;
        end
    end

    always_comb begin
        major_x = (s_mode == MODE_HORIZ) || (s_mode == MODE_RISE_LOW) ||
                  (s_mode == MODE_FALL_LOW);
        last    = (major_x ? s_x : s_y) == s_stop;
        a_x     = s_x;
        a_y     = s_y;
        a_dec   = s_dec;
        if (s_mode != MODE_HORIZ && s_mode != MODE_VERT) begin
            if (s_dec < 0) begin
                a_dec = s_dec + s_ss;
            end else begin
                a_dec = s_dec + s_sd;
                case (s_mode)
                    MODE_RISE_LOW: a_y = s_y + 1'b1;
                    MODE_FALL_LOW: a_y = s_y - 1'b1;
                    default:       a_x = s_x + 1'b1;
                endcase
            end
        end
        case (s_mode) inside
            MODE_HORIZ, MODE_RISE_LOW, MODE_FALL_LOW: a_x = a_x + 1'b1;
            MODE_FALL_STEEP:                          a_y = a_y - 1'b1;
            default:                                  a_y = a_y + 1'b1;
        endcase
    end

    always_comb begin
        busy_next    = busy_reg;
        mode_next    = mode_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        stop_next    = stop_reg;
        dec_next     = dec_reg;
        ss_next      = ss_reg;
        sd_next      = sd_reg;
        color_next   = color_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        px_next      = px_reg;
        py_next      = py_reg;
        pc_next      = pc_reg;
        plast_next   = plast_reg;
        if (emit) begin
            busy_next    = !last;
            mode_next    = s_mode;
            x_next       = a_x;
            y_next       = a_y;
            stop_next    = s_stop;
            dec_next     = a_dec;
            ss_next      = s_ss;
            sd_next      = s_sd;
            color_next   = s_color;
            m_valid_next = 1'b1;
            px_next      = s_x;
            py_next      = s_y;
            pc_next      = s_color;
            plast_next   = last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        stop_reg  <= stop_next;
        dec_reg   <= dec_next;
        ss_reg    <= ss_next;
        sd_reg    <= sd_next;
        color_reg <= color_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        pc_reg    <= pc_next;
        plast_reg <= plast_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_DATA_BITS'({pc_reg, py_reg, px_reg});
    assign m_axis_tlast  = plast_reg;

endmodule

### design/line_rasterizer.sv
// Top level of the midpoint line rasterizer.
// Depends on lr_pkg, lr_front, lr_queue and lr_back.
//
// A start beat (tuser = 0) gives two end points and a color and yields the
// line's first pixel; each step beat (tuser = 1) yields the next pixel, and the
// final pixel carries tlast. A step beat with no line in progress yields
// nothing, and a start beat abandons any line in progress. The block takes one
// beat per cycle and delivers one pixel per cycle when the output is not
// stalled. An accepted beat is first written into the command queue; its pixel
// is registered in the output register at the edge at which the beat leaves
// the queue, and can be taken from there. The rate is set by the stepper,
// which updates the decision term and position as it emits each pixel; a
// two-entry queue between setup and stepper lets either side stall alone.
module line_rasterizer
    import lr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [S_DATA_BITS-1:0] s_axis_tdata,  // start_x, start_y, end_x, end_y, line_color
    input  logic                   s_axis_tuser,  // kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [M_DATA_BITS-1:0] m_axis_tdata,  // pixel_x, pixel_y, pixel_color
    output logic                   m_axis_tlast   // last_pixel
);

    logic    push_valid, push_ready, pop_valid, pop_ready;
    lr_cmd_t push_data, pop_data;

    lr_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    lr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
